[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property every clock edge outside reset.
`define RTS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define RTS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/rts_pkg.sv]
`default_nettype none

package rts_pkg;

  localparam int MAX_CITIES_DEF = 1024;
  localparam int RAND_BITS_DEF  = 31;

  localparam int CNT_W    = 11;
  localparam int CITY_W   = 10;
  localparam int IDX_IN_W = 10;
  localparam int RAND_W   = 31;
  localparam int OP_W     = 2;

  localparam logic [CNT_W-1:0] CITY_COUNT_RST = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_START   = 2'd0,
    OP_SHUFFLE = 2'd1,
    OP_READ    = 2'd2,
    OP_NOP     = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e               opcode;
    logic [RAND_W-1:0]     rand_word;
    logic [IDX_IN_W-1:0]   read_index;
  } rts_in_t;

  typedef struct packed {
    logic [CITY_W-1:0] city;
    logic              done_res;
    logic              out_of_range;
  } rts_out_t;

  typedef struct packed {
    logic latch_in;
    logic load_cnt;
    logic fill_clr;
    logic fill_wr;
    logic div_step;
    logic rd_a;
    logic rd_b;
    logic wr_a;
    logic wr_b;
    logic dec_cnt;
    logic rd_entry;
    logic put_result;
  } dp_cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    fill_done;
    logic    div_last;
    logic    k_zero;
    logic    can_shuffle;
    logic    in_range;
    logic    out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

[sv/rts_stream_if.sv]
`default_nettype none

interface rts_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/rts_ctrl.sv]
`default_nettype none

module rts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rts_pkg::dp_sts_t  sts_i,
  output rts_pkg::dp_cmd_t  cmd_o
);
  import rts_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_FILL   = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_RD_A   = 4'd4;
  localparam logic [3:0] S_RD_B   = 4'd5;
  localparam logic [3:0] S_WR_A   = 4'd6;
  localparam logic [3:0] S_WR_B   = 4'd7;
  localparam logic [3:0] S_PUT    = 4'd8;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.op)
          OP_START: begin
            cmd_o.load_cnt = 1'b1;
            cmd_o.fill_clr = 1'b1;
            state_d        = S_FILL;
          end
          OP_SHUFFLE: begin
            // a finished shuffle ignores further steps
            state_d = sts_i.can_shuffle ? S_DIV : S_PUT;
          end
          OP_READ: begin
            cmd_o.rd_entry = sts_i.in_range;
            state_d        = S_PUT;
          end
          default: begin
            state_d = S_PUT;
          end
        endcase
      end
      S_FILL: begin
        if (sts_i.fill_done) begin
          state_d = S_PUT;
        end else begin
          cmd_o.fill_wr = 1'b1;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_RD_A;
        end
      end
      S_RD_A: begin
        // k of zero: no swap, just count down
        if (sts_i.k_zero) begin
          cmd_o.dec_cnt = 1'b1;
          state_d       = S_PUT;
        end else begin
          cmd_o.rd_a = 1'b1;
          state_d    = S_RD_B;
        end
      end
      S_RD_B: begin
        cmd_o.rd_b = 1'b1;
        state_d    = S_WR_A;
      end
      S_WR_A: begin
        cmd_o.wr_a = 1'b1;
        state_d    = S_WR_B;
      end
      S_WR_B: begin
        cmd_o.wr_b    = 1'b1;
        cmd_o.dec_cnt = 1'b1;
        state_d       = S_PUT;
      end
      S_PUT: begin
        // hold until the output register frees
        if (sts_i.out_free) begin
          cmd_o.put_result = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/rts_dp.sv]
`default_nettype none

module rts_dp #(
  parameter int MAX_CITIES = rts_pkg::MAX_CITIES_DEF,
  parameter int RAND_BITS  = rts_pkg::RAND_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rts_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  rts_pkg::rts_in_t           in_data_i,
  input  rts_pkg::dp_cmd_t           cmd_i,
  output rts_pkg::dp_sts_t           sts_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rts_pkg::rts_out_t          out_data_o
);
  import rts_pkg::*;

  localparam int IDX_W    = $clog2(MAX_CITIES);
  localparam int DIV_W    = (RAND_BITS < RAND_W) ? RAND_BITS : RAND_W;
  localparam int STEP_W   = $clog2(DIV_W);
  localparam int CNT_TOP  = (2 ** CNT_W) - 1;
  localparam int MAX_CLIP = (MAX_CITIES > CNT_TOP) ? CNT_TOP : MAX_CITIES;
  localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_CLIP);
  localparam logic [STEP_W-1:0] STEP_END = STEP_W'(DIV_W - 1);

  logic [CNT_W-1:0]    city_count_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [CNT_W-1:0]    fill_q;
  opcode_e             op_q;
  logic [IDX_IN_W-1:0] idx_q;
  logic [DIV_W-1:0]    dividend_q;
  logic [CNT_W-1:0]    rem_q;
  logic [STEP_W-1:0]   step_q;
  logic [CITY_W-1:0]   tmp_q;
  logic [CITY_W-1:0]   rdata_q;
  logic                out_valid_q;
  rts_out_t            out_data_q;

  logic [CITY_W-1:0]   store_mem [MAX_CITIES];

  logic [CNT_W-1:0]    eff_count;
  logic                in_range;
  logic [CNT_W-1:0]    last_pos;
  logic [CNT_W:0]      shifted;
  logic [CNT_W:0]      diff;
  logic                fits;
  logic                mem_we;
  logic                mem_re;
  logic [IDX_W-1:0]    mem_addr;
  logic [CITY_W-1:0]   mem_wdata;

  // a count above capacity acts as full capacity
  assign eff_count = (city_count_q > MAX_CNT) ? MAX_CNT : city_count_q;
  assign in_range  = CNT_W'(idx_q) < eff_count;
  assign last_pos  = cnt_q - CNT_W'(1);

  // restoring divider, one quotient bit a cycle; only the remainder is kept
  assign shifted = {rem_q, dividend_q[DIV_W-1]};
  assign diff    = shifted - {1'b0, cnt_q};
  assign fits    = shifted >= {1'b0, cnt_q};

  assign sts_o.op          = op_q;
  assign sts_o.fill_done   = fill_q >= eff_count;
  assign sts_o.div_last    = step_q == STEP_END;
  assign sts_o.k_zero      = rem_q == '0;
  assign sts_o.can_shuffle = cnt_q > CNT_W'(2);
  assign sts_o.in_range    = in_range;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      city_count_q <= CITY_COUNT_RST;
      cnt_q        <= '0;
      fill_q       <= '0;
      op_q         <= OP_NOP;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        city_count_q <= cfg_wdata_i;
      end
      if (cmd_i.latch_in) begin
        op_q <= in_data_i.opcode;
      end
      if (cmd_i.load_cnt) begin
        cnt_q <= eff_count;
      end else if (cmd_i.dec_cnt) begin
        cnt_q <= last_pos;
      end
      if (cmd_i.fill_clr) begin
        fill_q <= '0;
      end else if (cmd_i.fill_wr) begin
        fill_q <= fill_q + CNT_W'(1);
      end
      if (cmd_i.put_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      idx_q      <= in_data_i.read_index;
      dividend_q <= in_data_i.rand_word[DIV_W-1:0];
      rem_q      <= '0;
      step_q     <= '0;
    end else if (cmd_i.div_step) begin
      dividend_q <= dividend_q << 1;
      rem_q      <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      step_q     <= step_q + STEP_W'(1);
    end
    if (cmd_i.rd_b) begin
      tmp_q <= rdata_q;
    end
    if (cmd_i.put_result) begin
      out_data_q.city         <= (op_q == OP_READ && in_range) ? rdata_q : '0;
      out_data_q.done_res     <= cnt_q <= CNT_W'(2);
      out_data_q.out_of_range <= (op_q == OP_READ) && !in_range;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    if (cmd_i.fill_wr) begin
      mem_we    = 1'b1;
      mem_addr  = IDX_W'(fill_q);
      mem_wdata = CITY_W'(fill_q);
    end else if (cmd_i.rd_a) begin
      mem_re   = 1'b1;
      mem_addr = IDX_W'(last_pos);
    end else if (cmd_i.rd_b) begin
      mem_re   = 1'b1;
      mem_addr = IDX_W'(rem_q);
    end else if (cmd_i.wr_a) begin
      // entry k goes to the top position
      mem_we    = 1'b1;
      mem_addr  = IDX_W'(last_pos);
      mem_wdata = rdata_q;
    end else if (cmd_i.wr_b) begin
      mem_we    = 1'b1;
      mem_addr  = IDX_W'(rem_q);
      mem_wdata = tmp_q;
    end else if (cmd_i.rd_entry) begin
      mem_re   = 1'b1;
      mem_addr = IDX_W'(idx_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= store_mem[mem_addr];
    end
  end

endmodule

`default_nettype wire

[sv/random_tour_shuffle_top.sv]
// Channel   Dir   Payload                             Handshake
// in_i      in    opcode, rand_word, read_index       valid/ready
// out_o     out   city, done_res, out_of_range        valid/ready
// cfg       in    city_count                          cfg_we_i, no wait
//
// A shuffle step runs the one-bit-per-cycle remainder divider over min(RAND_BITS, 31)
// bits of rand_word, then four single-port store accesses; when k is zero these are skipped.
// Start writes one entry per city of the effective city count. Read, finished shuffle
// step or no-op go straight to the result; a new word is taken once the last is put.
// Reset clears control and sets city_count to 1024; the store is not reset and holds no tour until a start.
// A stalled result holds in the output register while the next word is taken.
`default_nettype none

module random_tour_shuffle_top #(
  parameter int MAX_CITIES = rts_pkg::MAX_CITIES_DEF,
  parameter int RAND_BITS  = rts_pkg::RAND_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rts_pkg::CNT_W-1:0] cfg_wdata_i,
  rts_stream_if.sink                in_i,
  rts_stream_if.source              out_o
);
  import rts_pkg::*;

  dp_cmd_t  cmd;
  dp_sts_t  sts;
  logic     in_ready;
  logic     out_valid;
  rts_out_t out_data;
  rts_in_t  in_data;

  assign in_data     = in_i.data;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

  rts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rts_dp #(
    .MAX_CITIES (MAX_CITIES),
    .RAND_BITS  (RAND_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

endmodule

`default_nettype wire

[sv/rts_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module rts_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input rts_pkg::rts_out_t out_data_i
);
  import rts_pkg::*;

  `RTS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "output word dropped while stalled")
  `RTS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_data_i), "output word changed while stalled")
  `RTS_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i && !$rose(out_valid_i), "word taken while another is in work")
  `RTS_ASSERT(a_oor_city_zero, clk_i, rst_ni, !(out_valid_i && out_data_i.out_of_range) || out_data_i.city == '0, "out-of-range read returned a city")

endmodule

bind random_tour_shuffle_top rts_checker u_rts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
